// ----- hw/rtl/sed_pkg.sv -----
// Shared types, character codes and helper functions for the string escape decoder.
package sed_pkg;

  // Escape decoding modes, one-hot encoded.
  typedef enum logic [4:0] {
    MODE_PLAIN = 5'b00001,
    MODE_ESC   = 5'b00010,
    MODE_X0    = 5'b00100,
    MODE_X1    = 5'b01000,
    MODE_OCT   = 5'b10000
  } mode_e;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerE    = 8'h65;
  localparam logic [7:0] ChUpperE    = 8'h45;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChUpperX    = 8'h58;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChReturn    = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] EscCode     = 8'd27;

  // Decoded results of one input byte, ready for the output buffer.
  typedef struct packed {
    logic [1:0]                  count;
    logic                        last;
    logic [MaxResults-1:0][7:0]  data;
  } res_t;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      v = c[3:0] + 4'd9;
    end else begin
      v = 4'hF;
    end
    return v;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c inside {[8'h30:8'h37]};
  endfunction

endpackage

// ----- hw/rtl/sed_decode.sv -----
// Escape state registers and the combinational decode of one registered input byte.
module sed_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [7:0]    byte_i,
  input  logic          last_i,
  output sed_pkg::res_t res_o
);
  import sed_pkg::*;

  mode_e      mode_q, mode_d;
  logic [7:0] held_q, held_d;
  logic [8:0] oval_q, oval_d;
  logic [1:0] ocnt_q, ocnt_d;

  logic [1:0]                 n;
  logic [MaxResults-1:0][7:0] data;
  logic [1:0]                 ocnt_inc;

  assign ocnt_inc = ocnt_q + 2'd1;

  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    oval_d = oval_q;
    ocnt_d = ocnt_q;
    n      = 2'd0;
    data   = '0;

    case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_PLAIN;
        if (byte_i == ChLowerN) begin
          data[n] = ChNewline; n = n + 2'd1;
        end else if (byte_i == ChLowerR) begin
          data[n] = ChReturn; n = n + 2'd1;
        end else if (byte_i == ChLowerT) begin
          data[n] = ChTab; n = n + 2'd1;
        end else if (byte_i == ChBackslash || byte_i == ChQuote) begin
          data[n] = byte_i; n = n + 2'd1;
        end else if (byte_i == ChLowerE || byte_i == ChUpperE) begin
          data[n] = EscCode; n = n + 2'd1;
        end else if (byte_i == ChLowerX || byte_i == ChUpperX) begin
          if (last_i) begin
            data[n] = ChLowerX; n = n + 2'd1;
          end else begin
            mode_d = MODE_X0;
          end
        end else if (is_oct(byte_i)) begin
          oval_d = {6'd0, byte_i[2:0]};
          ocnt_d = 2'd0;
          if (last_i) begin
            data[n] = {5'd0, byte_i[2:0]}; n = n + 2'd1;
          end else begin
            mode_d = MODE_OCT;
          end
        end else begin
          data[n] = byte_i; n = n + 2'd1;
        end
      end
      MODE_X0: begin
        if (is_hex(byte_i) && !last_i) begin
          held_d = byte_i;
          mode_d = MODE_X1;
        end else begin
          data[n] = ChLowerX; n = n + 2'd1;
          if (byte_i == ChBackslash && !last_i) begin
            mode_d = MODE_ESC;
          end else begin
            mode_d = MODE_PLAIN;
            data[n] = byte_i; n = n + 2'd1;
          end
        end
      end
      MODE_X1: begin
        if (is_hex(byte_i)) begin
          data[n] = {hex_nib(held_q), hex_nib(byte_i)}; n = n + 2'd1;
          mode_d = MODE_PLAIN;
        end else begin
          // A broken hex escape replays the x and the held digit as text.
          data[n] = ChLowerX; n = n + 2'd1;
          data[n] = held_q;   n = n + 2'd1;
          if (byte_i == ChBackslash && !last_i) begin
            mode_d = MODE_ESC;
          end else begin
            mode_d = MODE_PLAIN;
            data[n] = byte_i; n = n + 2'd1;
          end
        end
      end
      MODE_OCT: begin
        if (is_oct(byte_i)) begin
          oval_d = {oval_q[5:0], byte_i[2:0]};
          ocnt_d = ocnt_inc;
          if (ocnt_inc >= 2'd2 || last_i) begin
            data[n] = {oval_q[4:0], byte_i[2:0]}; n = n + 2'd1;
            mode_d = MODE_PLAIN;
          end
        end else begin
          data[n] = oval_q[7:0]; n = n + 2'd1;
          if (byte_i == ChBackslash && !last_i) begin
            mode_d = MODE_ESC;
          end else begin
            mode_d = MODE_PLAIN;
            data[n] = byte_i; n = n + 2'd1;
          end
        end
      end
      default: begin
        if (byte_i == ChBackslash && !last_i) begin
          mode_d = MODE_ESC;
        end else begin
          mode_d = MODE_PLAIN;
          data[n] = byte_i; n = n + 2'd1;
        end
      end
    endcase

    if (last_i) begin
      mode_d = MODE_PLAIN;
    end
  end

  assign res_o.count = n;
  assign res_o.last  = last_i;
  assign res_o.data  = data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      held_q <= '0;
      oval_q <= '0;
      ocnt_q <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      held_q <= held_d;
      oval_q <= oval_d;
      ocnt_q <= ocnt_d;
    end
  end

  // The end of a body always produces output and always leaves plain mode behind.
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && last_i |-> res_o.count != 2'd0)
    else $error("final byte produced no decoded byte");

  a_last_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && last_i |=> mode_q == MODE_PLAIN)
    else $error("escape state survived the end of a body");

  a_mode_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mode_q))
    else $error("escape mode register lost its one-hot code");

endmodule

// ----- hw/rtl/sed_outbuf.sv -----
// Result register that holds up to three decoded bytes and hands them out one at a time.
module sed_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  sed_pkg::res_t res_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    byte_out_o,
  output logic          out_last_o
);
  import sed_pkg::*;

  logic [MaxResults-1:0][7:0] data_q;
  logic [1:0]                 cnt_q;
  logic [1:0]                 idx_q;
  logic                       last_q;
  logic [1:0]                 final_idx;
  logic                       at_final;
  logic                       out_fire;

  assign final_idx   = cnt_q - 2'd1;
  assign at_final    = (idx_q == final_idx);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign byte_out_o  = data_q[idx_q];
  assign out_last_o  = last_q && at_final;
  // The buffer can be refilled once its last byte leaves in this cycle.
  assign space_o     = !out_valid_o || (out_ready_i && at_final);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= res_i.count;
      idx_q <= '0;
    end else if (out_fire) begin
      if (at_final) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i.data;
      last_q <= res_i.last;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < cnt_q)
    else $error("output index points past the buffered bytes");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !out_valid_o || (out_fire && at_final))
    else $error("buffer reloaded while bytes were still pending");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i && res_i.count != 2'd0 |=> out_valid_o && idx_q == 2'd0)
    else $error("loaded results did not appear at the output");

endmodule

// ----- hw/rtl/string_escape_decoder_top.sv -----
// Top level of the string escape decoder: input register, decoder and result buffer.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_ready_o  byte_in_i, end_of_body_i
//   out      output     out_valid_o/out_ready_i  byte_out_o, out_last_o
//
// An accepted byte sits in the input register until the buffer has space, is decoded in one
// pass, and its zero to three decoded bytes go out one per cycle, while out_ready_i is high,
// from the result buffer. Sustained rate is one byte per cycle while no byte yields more
// than one result and out_ready_i stays high; else the input waits for the buffer to drain.
// Reset returns the decoder to plain mode and empties both registers.
// Output stalls hold the buffer and, once the input register is full, the input.
module string_escape_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       end_of_body_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] byte_out_o,
  output logic       out_last_o
);
  import sed_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       space;
  logic       advance;
  res_t       res;

  assign advance    = valid_q && space;
  assign in_ready_o = !valid_q || space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_in_i;
      last_q <= end_of_body_i;
    end
  end

  sed_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .byte_i (byte_q),
    .last_i (last_q),
    .res_o  (res)
  );

  sed_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .byte_out_o  (byte_out_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ----- test/tb_top.sv -----
// Testbench for the string escape decoder: directed and random byte streams, checked by a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } decoded_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } ready_style_e;

  localparam logic [7:0] ChZero = 8'h30;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] byte_in_i     = 8'h00;
  logic       end_of_body_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [7:0] byte_out_o;
  logic       out_last_o;

  // Decoder state as the predictor sees it.
  mode_e      dec_mode;
  logic [7:0] dec_held;
  logic [8:0] dec_octal;
  logic [1:0] dec_octal_taken;

  decoded_t     pending_bytes[$];
  int           mismatches  = 0;
  int           bytes_sent  = 0;
  int           burst_left  = 0;
  bit           gaps_on     = 1'b1;
  int unsigned  ready_cycle = 0;
  ready_style_e ready_style = READY_ALWAYS;

  logic [7:0] simple_escapes[7] = '{ChLowerN, ChLowerR, ChLowerT, ChBackslash, ChQuote,
                                    ChLowerE, ChUpperE};
  string      hex_chars = "0123456789abcdefABCDEF";

  string_escape_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .end_of_body_i (end_of_body_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .byte_out_o    (byte_out_o),
    .out_last_o    (out_last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int hex_digit_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return -1;
  endfunction

  function automatic bit is_octal_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] b);
    q.insert(q.size(), b);
  endfunction

  function automatic void take_plain(input logic [7:0] b, input logic last,
                                     ref logic [7:0] produced[$]);
    if (b == ChBackslash && !last) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_PLAIN;
      put_byte(produced, b);
    end
  endfunction

  // Advances the predicted decoder state by one input byte and queues its decoded bytes.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [7:0] produced[$];
    int         hi;
    int         lo;
    decoded_t   d;
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_PLAIN;
        if (b == ChLowerN) put_byte(produced, ChNewline);
        else if (b == ChLowerR) put_byte(produced, ChReturn);
        else if (b == ChLowerT) put_byte(produced, ChTab);
        else if (b == ChBackslash || b == ChQuote) put_byte(produced, b);
        else if (b == ChLowerE || b == ChUpperE) put_byte(produced, EscCode);
        else if (b == ChLowerX || b == ChUpperX) begin
          if (last) put_byte(produced, ChLowerX);
          else dec_mode = MODE_X0;
        end else if (is_octal_digit(b)) begin
          dec_octal = {1'b0, b - ChZero};
          dec_octal_taken = 2'd0;
          if (last) put_byte(produced, dec_octal[7:0]);
          else dec_mode = MODE_OCT;
        end else begin
          put_byte(produced, b);
        end
      end
      MODE_X0: begin
        if (hex_digit_val(b) >= 0 && !last) begin
          dec_held = b;
          dec_mode = MODE_X1;
        end else begin
          put_byte(produced, ChLowerX);
          take_plain(b, last, produced);
        end
      end
      MODE_X1: begin
        if (hex_digit_val(b) >= 0) begin
          hi = hex_digit_val(dec_held) & 15;
          lo = hex_digit_val(b);
          put_byte(produced, 8'((hi << 4) | lo));
          dec_mode = MODE_PLAIN;
        end else begin
          put_byte(produced, ChLowerX);
          put_byte(produced, dec_held);
          take_plain(b, last, produced);
        end
      end
      MODE_OCT: begin
        if (is_octal_digit(b)) begin
          dec_octal = (dec_octal << 3) + (b - ChZero);
          dec_octal_taken = dec_octal_taken + 2'd1;
          if (dec_octal_taken >= 2'd2 || last) begin
            put_byte(produced, dec_octal[7:0]);
            dec_mode = MODE_PLAIN;
          end
        end else begin
          put_byte(produced, dec_octal[7:0]);
          take_plain(b, last, produced);
        end
      end
      default: take_plain(b, last, produced);
    endcase
    if (last) dec_mode = MODE_PLAIN;
    foreach (produced[i]) begin
      d.data = produced[i];
      d.last = last && (i == produced.size() - 1);
      pending_bytes.insert(pending_bytes.size(), d);
    end
  endfunction

  // Drives one byte and holds it until the transaction completes; gaps fall between bursts.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gaps_on && gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    byte_in_i     <= b;
    end_of_body_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_body(input logic [7:0] body[$]);
    foreach (body[i]) send_byte(body[i], i == body.size() - 1);
  endtask

  // Appends one piece of a string body: mostly well-formed escapes, some broken ones.
  function automatic void append_token(ref logic [7:0] body[$]);
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        put_byte(body, 8'($urandom_range(8'h20, 8'h7E)));
      end
      2: begin
        put_byte(body, ChBackslash);
        put_byte(body, simple_escapes[$urandom_range(0, 6)]);
      end
      3, 4: begin
        put_byte(body, ChBackslash);
        put_byte(body, $urandom_range(0, 1) ? ChLowerX : ChUpperX);
        put_byte(body, hex_chars[$urandom_range(0, 21)]);
        put_byte(body, hex_chars[$urandom_range(0, 21)]);
      end
      5, 6: begin
        n = $urandom_range(1, 4);
        put_byte(body, ChBackslash);
        repeat (n) put_byte(body, ChZero + 8'($urandom_range(0, 7)));
      end
      7: begin
        put_byte(body, ChBackslash);
        put_byte(body, ChLowerX);
        if ($urandom_range(0, 1)) put_byte(body, hex_chars[$urandom_range(0, 21)]);
        put_byte(body, 8'($urandom_range(0, 255)));
      end
      8: begin
        put_byte(body, ChBackslash);
        put_byte(body, 8'($urandom_range(0, 255)));
      end
      default: begin
        put_byte(body, 8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  task automatic test_simple_escapes();
    send_body('{ChBackslash, ChLowerN, ChBackslash, ChUpperE, 8'hFF});
  endtask

  task automatic test_hex_escapes();
    send_body('{ChBackslash, ChLowerX, "4", "f", ChBackslash, ChUpperX, "g"});
    // A bad second digit gives back the x, the held digit and the byte itself.
    send_body('{ChBackslash, ChLowerX, "A", "z"});
    send_body('{ChBackslash, ChLowerX, "A"});
  endtask

  task automatic test_octal_escapes();
    send_body('{ChBackslash, "3", "7", "7", ChBackslash, "1", "9"});
    send_body('{ChBackslash, "5"});
  endtask

  task automatic test_trailing_backslash();
    send_body('{ChBackslash});
  endtask

  task automatic test_random_bodies(input int count);
    logic [7:0] body[$];
    int         stop_at;
    int         tokens;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      body.delete();
      tokens = $urandom_range(1, 6);
      repeat (tokens) append_token(body);
      send_body(body);
    end
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    test_random_bodies(count);
    gaps_on = 1'b1;
  endtask

  // Loose bytes, heavy on backslashes, with the end of body set at random.
  task automatic test_noise(input int count);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = ($urandom_range(0, 3) == 0) ? ChBackslash : 8'($urandom_range(0, 255));
      send_byte(b, ($urandom_range(0, 7) == 0) || (i == count - 1));
    end
  endtask

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte 0x%02h last %0b", $time, byte_out_o, out_last_o);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (byte_out_o !== want.data) begin
          $display("%0t: byte expected 0x%02h actual 0x%02h", $time, want.data, byte_out_o);
          mismatches++;
        end
        if (out_last_o !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_last_o);
          mismatches++;
        end
      end
    end
    ready_cycle++;
    if (ready_cycle % 64 == 0) ready_style = ready_style_e'($urandom_range(0, 3));
    case (ready_style)
      READY_ALWAYS:   out_ready_i <= 1'b1;
      READY_COIN:     out_ready_i <= 1'($urandom_range(0, 1));
      READY_PERIODIC: out_ready_i <= (ready_cycle % 4 != 3);
      default:        out_ready_i <= ($urandom_range(0, 5) == 0);
    endcase
  end

  initial begin
    dec_mode        = MODE_PLAIN;
    dec_held        = 8'h00;
    dec_octal       = 9'h000;
    dec_octal_taken = 2'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_simple_escapes();
    test_hex_escapes();
    test_octal_escapes();
    test_trailing_backslash();
    test_random_bodies(270);
    test_back_to_back(60);
    test_noise(70);
    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
